### hdl/dqu_pkg.sv
// dqu_pkg: shared types, constants and codes for the double-ended queue unit
// no dependencies; imported by dqu_ctrl, dqu_dp and double_ended_queue_unit
`default_nettype none

package dqu_pkg;

    // storage geometry
    localparam int DEPTH = 1024;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;

    // fixed field widths of the transactions
    localparam int FUNC_W      = 3;
    localparam int VAL_W       = 32;
    localparam int IDX_W       = 10;
    localparam int STATUS_W    = 2;
    localparam int CNT_OUT_W   = 11;
    localparam int CMP_W       = (IDX_W > CNT_W) ? IDX_W : CNT_W;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH_BACK  = 3'd0,
        FUNC_PUSH_FRONT = 3'd1,
        FUNC_POP_BACK   = 3'd2,
        FUNC_POP_FRONT  = 3'd3,
        FUNC_READ_IDX   = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [VAL_W-1:0]  value;
        logic [IDX_W-1:0]         index;
    } t_req;

    typedef struct packed {
        logic signed [VAL_W-1:0]  read_value;
        logic [STATUS_W-1:0]      status;
        logic [CNT_OUT_W-1:0]     item_count;
        logic                     is_empty;
    } t_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
    } t_dp_cmd;

endpackage

`default_nettype wire

### hdl/double_ended_queue_unit.sv
// double_ended_queue_unit: top level of the double-ended queue of 32-bit values
// depends on dqu_pkg, dqu_ctrl (sequencer) and dqu_dp (pointers and memory)
//
// usage:
//   requests arrive on i_in_req with i_in_valid; the unit holds o_in_stall high
//   while it is busy. a request transaction completes when valid is high and
//   stall is low. every request yields exactly one result transaction on
//   o_out_res with o_out_valid, taken when i_out_stall is low.
//   sequence: the accept edge captures the request; the execute state (pointer
//   update, memory write or memory read into the read data register) follows,
//   and the result is valid from the edge that ends it; with no stall it is
//   taken at the edge that ends the respond state.
//   requests: the unit handles one at a time; the next request is taken in the
//   same cycle the current result leaves.
//   stall: while i_out_stall is high the result stays valid and unchanged and
//   no new request is taken.
//   reset: i_rst_n low at a clock edge empties the queue (front pointer and
//   count zero); memory contents are not cleared and only written entries are
//   ever read. no clearing pass is needed, the unit is ready right after reset.
`default_nettype none

module double_ended_queue_unit
    import dqu_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    // request channel
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_req    i_in_req,
    // result channel
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_res         o_out_res
);

    // commands from the sequencer to the datapath
    t_dp_cmd w_cmd;

    // sequencer: idle / execute / respond
    dqu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    // datapath: captures the request, executes it, holds the result registers
    dqu_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (i_in_req),
        .o_res   (o_out_res)
    );

endmodule

`default_nettype wire

### hdl/dqu_ctrl.sv
// dqu_ctrl: request sequencing state machine for the double-ended queue unit
// depends on dqu_pkg; drives the handshakes and the datapath commands
`default_nettype none

module dqu_ctrl
    import dqu_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        w_take      = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                w_take     = i_in_valid;
                if (w_take) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_RESP;
            end
            S_RESP: begin
                o_out_valid = 1'b1;
                // a new request may enter in the cycle the result leaves
                o_in_stall  = i_out_stall;
                w_take      = i_in_valid && !i_out_stall;
                if (!i_out_stall) begin
                    n_state = w_take ? S_EXEC : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd.capture = w_take;
    end

    resp_hold_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && i_out_stall) |=> (r_state == S_RESP))
        else $error("result dropped while stalled");

    exec_after_take_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_EXEC))
        else $error("accepted request not executed");

    one_exec_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> !o_cmd.exec)
        else $error("request executed twice");

endmodule

`default_nettype wire

### hdl/dqu_dp.sv
// dqu_dp: pointers, entry count, entry memory and result registers of the queue
// depends on dqu_pkg; commanded by dqu_ctrl
`default_nettype none

module dqu_dp
    import dqu_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_dp_cmd i_cmd,
    input  wire t_req    i_req,
    output t_res         o_res
);

    logic signed [VAL_W-1:0] r_mem [DEPTH];

    t_req                    r_req;
    logic [PTR_W-1:0]        r_front;
    logic [CNT_W-1:0]        r_count;
    logic [PTR_W-1:0]        n_front;
    logic [CNT_W-1:0]        n_count;
    t_status                 r_status;
    t_status                 n_status;
    logic                    r_use_rd;
    logic                    n_use_rd;
    logic signed [VAL_W-1:0] r_rd_data;

    logic                    w_full;
    logic                    w_empty;
    logic                    w_in_range;
    logic                    w_we;
    logic                    w_re;
    logic [PTR_W-1:0]        w_addr;
    logic [PTR_W-1:0]        w_back_pos;
    logic [PTR_W-1:0]        w_last_pos;
    logic [PTR_W-1:0]        w_idx_pos;
    logic [PTR_W-1:0]        w_front_inc;
    logic [PTR_W-1:0]        w_front_dec;
    logic [SUM_W-1:0]        w_front_ext;
    logic [SUM_W-1:0]        w_cnt_ext;

    function automatic logic [PTR_W-1:0] wrap_pos(input logic [SUM_W-1:0] p);
        wrap_pos = (p >= DEPTH_SUM) ? PTR_W'(p - DEPTH_SUM) : PTR_W'(p);
    endfunction

    assign w_full      = (r_count == DEPTH_CNT);
    assign w_empty     = (r_count == '0);
    assign w_in_range  = (CMP_W'(r_req.index) < CMP_W'(r_count));
    assign w_front_ext = SUM_W'(r_front);
    assign w_cnt_ext   = SUM_W'(r_count);
    assign w_back_pos  = wrap_pos(w_front_ext + w_cnt_ext);
    assign w_last_pos  = wrap_pos(w_front_ext + w_cnt_ext - SUM_W'(1));
    assign w_idx_pos   = wrap_pos(w_front_ext + SUM_W'(r_req.index));
    assign w_front_inc = wrap_pos(w_front_ext + SUM_W'(1));
    assign w_front_dec = (r_front == '0) ? LAST_PTR : r_front - PTR_W'(1);

    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_status = ST_OK;
        n_use_rd = 1'b0;
        w_we     = 1'b0;
        w_re     = 1'b0;
        w_addr   = r_front;
        unique case (r_req.func)
            FUNC_PUSH_BACK: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_we    = 1'b1;
                    w_addr  = w_back_pos;
                    n_count = r_count + CNT_W'(1);
                end
            end
            FUNC_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_we    = 1'b1;
                    w_addr  = w_front_dec;
                    n_front = w_front_dec;
                    n_count = r_count + CNT_W'(1);
                end
            end
            FUNC_POP_BACK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_re     = 1'b1;
                    n_use_rd = 1'b1;
                    w_addr   = w_last_pos;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            FUNC_POP_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_re     = 1'b1;
                    n_use_rd = 1'b1;
                    w_addr   = r_front;
                    n_front  = w_front_inc;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            FUNC_READ_IDX: begin
                if (!w_in_range) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_re     = 1'b1;
                    n_use_rd = 1'b1;
                    w_addr   = w_idx_pos;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_use_rd <= n_use_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    // entry memory, one port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_we) begin
            r_mem[w_addr] <= r_req.value;
        end
        if (i_cmd.exec && w_re) begin
            r_rd_data <= r_mem[w_addr];
        end
    end

    assign o_res.read_value = r_use_rd ? r_rd_data : '0;
    assign o_res.status     = r_status;
    assign o_res.item_count = CNT_OUT_W'(r_count);
    assign o_res.is_empty   = (r_count == '0);

    count_bound_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= DEPTH_CNT))
        else $error("entry count beyond depth");

    front_bound_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SUM_W'(r_front) < DEPTH_SUM))
        else $error("front pointer outside store");

    fail_keeps_state_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && n_status != ST_OK) |=> ($stable(r_count) && $stable(r_front)))
        else $error("failed request changed the queue");

    push_counts_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && w_we) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("push did not add one entry");

endmodule

`default_nettype wire
